// ----- rtl/safq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the steering angle core: payload and config types, pipeline widths,
// the CORDIC arctangent table and register codes. It depends on nothing.
package safq_pkg;

    localparam int CORDIC_STAGES  = 16;
    localparam int ATAN_TABLE_LEN = 24;
    localparam int CSTAGES = (CORDIC_STAGES < ATAN_TABLE_LEN) ? CORDIC_STAGES : ATAN_TABLE_LEN;

    localparam int QW  = 16;  // quaternion component width
    localparam int PW  = 32;  // product width
    localparam int TW  = 34;  // t3 / t4 width
    localparam int XW  = 37;  // CORDIC x / y width
    localparam int AW  = 26;  // angle accumulator width, 2^-16 degree
    localparam int YW  = AW + 1 - 9;  // rounded yaw width, 1/128 degree
    localparam int SW  = 20;  // steering and display sums
    localparam int OW  = 16;  // output angle width
    localparam int PADDR_W = 5;

    localparam int HALF_TURN = 23040;
    localparam int FULL_TURN = 46080;
    localparam int HALF_DEG16 = 180 * 65536;
    localparam int ONE_Q28 = 1 << 28;

    typedef struct packed {
        logic signed [QW-1:0] frame_qw;
        logic signed [QW-1:0] frame_qx;
        logic signed [QW-1:0] frame_qy;
        logic signed [QW-1:0] frame_qz;
        logic signed [QW-1:0] fork_qw;
        logic signed [QW-1:0] fork_qx;
        logic signed [QW-1:0] fork_qy;
        logic signed [QW-1:0] fork_qz;
    } t_in_item;

    typedef struct packed {
        logic signed [OW-1:0] steering_angle;
        logic signed [OW-1:0] frame_yaw;
    } t_out_item;

    typedef struct packed {
        logic                 calibrated;
        logic signed [15:0]   frame_yaw_offset;
        logic signed [15:0]   fork_yaw_offset;
        logic signed [15:0]   steering_offset;
        logic signed [16:0]   display_yaw_offset;
    } t_cfg;

    // One vector in the CORDIC pipe.
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } t_cvec;

    typedef enum logic [2:0] {
        REG_CALIBRATED  = 3'd0,
        REG_FRAME_OFS   = 3'd1,
        REG_FORK_OFS    = 3'd2,
        REG_STEER_OFS   = 3'd3,
        REG_DISPLAY_OFS = 3'd4
    } t_reg_idx;

    // atan(2^-i) in degrees times 65536, rounded.
    function automatic logic signed [AW-1:0] atan_deg16(input int i);
        logic signed [AW-1:0] v;
        case (i)
            0:  v = AW'(2949120);
            1:  v = AW'(1740967);
            2:  v = AW'(919879);
            3:  v = AW'(466945);
            4:  v = AW'(234379);
            5:  v = AW'(117304);
            6:  v = AW'(58666);
            7:  v = AW'(29335);
            8:  v = AW'(14668);
            9:  v = AW'(7334);
            10: v = AW'(3667);
            11: v = AW'(1833);
            12: v = AW'(917);
            13: v = AW'(458);
            14: v = AW'(229);
            15: v = AW'(115);
            16: v = AW'(57);
            17: v = AW'(29);
            18: v = AW'(14);
            19: v = AW'(7);
            20: v = AW'(4);
            21: v = AW'(2);
            22: v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/safq_regs.sv -----
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port.
// Depends on safq_pkg.
module safq_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [safq_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output safq_pkg::t_cfg                o_cfg
);
    safq_pkg::t_cfg   r_cfg;
    safq_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = safq_pkg::t_reg_idx'(paddr[safq_pkg::PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                safq_pkg::REG_CALIBRATED:  r_cfg.calibrated         <= pwdata[0];
                safq_pkg::REG_FRAME_OFS:   r_cfg.frame_yaw_offset   <= pwdata[15:0];
                safq_pkg::REG_FORK_OFS:    r_cfg.fork_yaw_offset    <= pwdata[15:0];
                safq_pkg::REG_STEER_OFS:   r_cfg.steering_offset    <= pwdata[15:0];
                safq_pkg::REG_DISPLAY_OFS: r_cfg.display_yaw_offset <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            safq_pkg::REG_CALIBRATED:  prdata = {31'd0, r_cfg.calibrated};
            safq_pkg::REG_FRAME_OFS:   prdata = 32'(r_cfg.frame_yaw_offset);
            safq_pkg::REG_FORK_OFS:    prdata = 32'(r_cfg.fork_yaw_offset);
            safq_pkg::REG_STEER_OFS:   prdata = 32'(r_cfg.steering_offset);
            safq_pkg::REG_DISPLAY_OFS: prdata = 32'(r_cfg.display_yaw_offset);
            default:                   prdata = '0;
        endcase
    end

endmodule

// ----- rtl/safq_prep.sv -----
`timescale 1ns / 1ps
// Front end: quaternion products, then t3/t4 and the half-turn prerotation.
// Two register stages. Depends on safq_pkg.
module safq_prep (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  safq_pkg::t_in_item       i_item,
    output logic                     o_valid,
    output safq_pkg::t_cvec [1:0]    o_vec
);
    logic signed [safq_pkg::QW-1:0] w_qw [2];
    logic signed [safq_pkg::QW-1:0] w_qx [2];
    logic signed [safq_pkg::QW-1:0] w_qy [2];
    logic signed [safq_pkg::QW-1:0] w_qz [2];
    logic signed [safq_pkg::PW-1:0] r_wz [2];
    logic signed [safq_pkg::PW-1:0] r_xy [2];
    logic signed [safq_pkg::PW-1:0] r_yy [2];
    logic signed [safq_pkg::PW-1:0] r_zz [2];
    logic signed [safq_pkg::TW-1:0] w_t3 [2];
    logic signed [safq_pkg::TW-1:0] w_t4 [2];
    safq_pkg::t_cvec [1:0]          n_vec;
    safq_pkg::t_cvec [1:0]          r_vec;
    logic                           r_v1;
    logic                           r_v2;

    assign w_qw[0] = i_item.frame_qw;
    assign w_qx[0] = i_item.frame_qx;
    assign w_qy[0] = i_item.frame_qy;
    assign w_qz[0] = i_item.frame_qz;
    assign w_qw[1] = i_item.fork_qw;
    assign w_qx[1] = i_item.fork_qx;
    assign w_qy[1] = i_item.fork_qy;
    assign w_qz[1] = i_item.fork_qz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_wz[l] <= safq_pkg::PW'(w_qw[l]) * safq_pkg::PW'(w_qz[l]);
                r_xy[l] <= safq_pkg::PW'(w_qx[l]) * safq_pkg::PW'(w_qy[l]);
                r_yy[l] <= safq_pkg::PW'(w_qy[l]) * safq_pkg::PW'(w_qy[l]);
                r_zz[l] <= safq_pkg::PW'(w_qz[l]) * safq_pkg::PW'(w_qz[l]);
            end
            r_vec <= n_vec;
        end
    end

    // A vector with negative x is turned by a half turn so the CORDIC sees x >= 0.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_t3[l] = (safq_pkg::TW'(r_wz[l]) + safq_pkg::TW'(r_xy[l])) <<< 1;
            w_t4[l] = safq_pkg::TW'(safq_pkg::ONE_Q28)
                    - ((safq_pkg::TW'(r_yy[l]) + safq_pkg::TW'(r_zz[l])) <<< 1);
            n_vec[l].zero = (w_t3[l] == '0) && (w_t4[l] == '0);
            if (w_t4[l] < 0) begin
                n_vec[l].x   = -safq_pkg::XW'(w_t4[l]);
                n_vec[l].y   = -safq_pkg::XW'(w_t3[l]);
                n_vec[l].ang = (w_t3[l] >= 0) ? safq_pkg::AW'(safq_pkg::HALF_DEG16)
                                              : -safq_pkg::AW'(safq_pkg::HALF_DEG16);
            end else begin
                n_vec[l].x   = safq_pkg::XW'(w_t4[l]);
                n_vec[l].y   = safq_pkg::XW'(w_t3[l]);
                n_vec[l].ang = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_vec   = r_vec;

    a_prerot_x_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_vec[0].x >= 0) && (r_vec[1].x >= 0))
        else $error("prerotated x is negative");

endmodule

// ----- rtl/safq_cordic.sv -----
`timescale 1ns / 1ps
// Vectoring CORDIC for both sensor vectors, one register stage per iteration.
// Depends on safq_pkg.
module safq_cordic (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  safq_pkg::t_cvec [1:0]    i_vec,
    output logic                     o_valid,
    output safq_pkg::t_cvec [1:0]    o_vec
);
    localparam int NS = safq_pkg::CSTAGES;

    safq_pkg::t_cvec [1:0] w_stg [0:NS];
    logic [NS-1:0]         r_vld;

    assign w_stg[0] = i_vec;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        safq_pkg::t_cvec [1:0] n_stg;
        safq_pkg::t_cvec [1:0] r_stg;

        // A residue of exactly zero takes the negative branch.
        always_comb begin
            for (int l = 0; l < 2; l++) begin
                n_stg[l].zero = w_stg[s][l].zero;
                if (w_stg[s][l].y > 0) begin
                    n_stg[l].x   = w_stg[s][l].x + (w_stg[s][l].y >>> s);
                    n_stg[l].y   = w_stg[s][l].y - (w_stg[s][l].x >>> s);
                    n_stg[l].ang = w_stg[s][l].ang + safq_pkg::atan_deg16(s);
                end else begin
                    n_stg[l].x   = w_stg[s][l].x - (w_stg[s][l].y >>> s);
                    n_stg[l].y   = w_stg[s][l].y + (w_stg[s][l].x >>> s);
                    n_stg[l].ang = w_stg[s][l].ang - safq_pkg::atan_deg16(s);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg <= n_stg;
            end
        end

        assign w_stg[s+1] = r_stg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_vec   = w_stg[NS];

    // Vectoring never lets x shrink, so it stays non-negative to the end.
    a_cordic_x_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] |-> (w_stg[NS][0].x >= 0) && (w_stg[NS][1].x >= 0))
        else $error("CORDIC x went negative");

endmodule

// ----- rtl/safq_post.sv -----
`timescale 1ns / 1ps
// Back end: yaw rounding, offset correction and angle wrapping, three stages.
// Depends on safq_pkg.
module safq_post (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  safq_pkg::t_cvec [1:0]    i_vec,
    input  safq_pkg::t_cfg           i_cfg,
    output logic                     o_valid,
    output safq_pkg::t_out_item      o_item
);
    localparam int AW = safq_pkg::AW;
    localparam int YW = safq_pkg::YW;
    localparam int SW = safq_pkg::SW;

    logic signed [AW:0]   w_rnd [2];
    logic signed [YW-1:0] r_yaw [2];
    logic signed [SW-1:0] w_yf;
    logic signed [SW-1:0] w_yk;
    logic signed [SW-1:0] r_steer;
    logic signed [SW-1:0] r_disp;
    safq_pkg::t_out_item  r_out;
    logic                 r_va;
    logic                 r_vb;
    logic                 r_vc;

    // Brings an angle into [-180, 180] degrees; the limits themselves stay.
    function automatic logic signed [safq_pkg::OW-1:0] wrap_angle(
        input logic signed [SW-1:0] v
    );
        logic signed [SW-1:0] adj;
        logic signed [SW-1:0] res;
        adj = '0;
        for (int j = 0; j < 4; j++) begin
            if (v > SW'(safq_pkg::HALF_TURN + j * safq_pkg::FULL_TURN)) begin
                adj = adj - SW'(safq_pkg::FULL_TURN);
            end else if (v < -SW'(safq_pkg::HALF_TURN + j * safq_pkg::FULL_TURN)) begin
                adj = adj + SW'(safq_pkg::FULL_TURN);
            end
        end
        res = v + adj;
        return res[safq_pkg::OW-1:0];
    endfunction

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_rnd[l] = (AW+1)'(i_vec[l].ang) + (AW+1)'(256);
        end
    end

    always_comb begin
        w_yf = SW'(r_yaw[0]);
        w_yk = SW'(r_yaw[1]);
        if (i_cfg.calibrated) begin
            w_yf = w_yf - SW'(i_cfg.frame_yaw_offset);
            w_yk = w_yk - SW'(i_cfg.fork_yaw_offset) - SW'(i_cfg.steering_offset);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_yaw[l] <= i_vec[l].zero ? '0 : w_rnd[l][AW:9];
            end
            r_steer <= w_yk - w_yf;
            r_disp  <= w_yf - SW'(i_cfg.display_yaw_offset);
            r_out.steering_angle <= wrap_angle(r_steer);
            r_out.frame_yaw      <= wrap_angle(r_disp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    assign o_valid = r_vc;
    assign o_item  = r_out;

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc |-> (r_out.steering_angle <= 16'sd23040) && (r_out.steering_angle >= -16'sd23040)
              && (r_out.frame_yaw <= 16'sd23040) && (r_out.frame_yaw >= -16'sd23040))
        else $error("wrapped angle out of range");

endmodule

// ----- rtl/steering_angle_from_quaternions_core.sv -----
`timescale 1ns / 1ps
// Top level of the steering angle core: front end, CORDIC, back end, registers.
// Depends on safq_pkg, safq_regs, safq_prep, safq_cordic and safq_post.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_in_item  (t_in_item)
//  output    out        o_out_valid / i_out_stall  o_out_item (t_out_item)
//  config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One transaction enters per cycle while no result is held by i_out_stall; each
// passes the front end, one register stage per CORDIC iteration, then the back end.
// Reset is synchronous and active low; it clears valid bits and the registers.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module steering_angle_from_quaternions_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  safq_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output safq_pkg::t_out_item           o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [safq_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    safq_pkg::t_cfg        w_cfg;
    safq_pkg::t_cvec [1:0] w_prep_vec;
    safq_pkg::t_cvec [1:0] w_cord_vec;
    logic                  w_prep_vld;
    logic                  w_cord_vld;
    logic                  w_en;

    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    safq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    safq_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_valid (w_prep_vld),
        .o_vec   (w_prep_vec)
    );

    safq_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_prep_vld),
        .i_vec   (w_prep_vec),
        .o_valid (w_cord_vld),
        .o_vec   (w_cord_vec)
    );

    safq_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cord_vld),
        .i_vec   (w_cord_vec),
        .i_cfg   (w_cfg),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no pending result");

endmodule

// ----- dv/steering_angle_from_quaternions_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for steering_angle_from_quaternions_core: directed table, then
// random quaternion pairs, checked against an integer yaw/steering predictor.
// Depends on safq_pkg and the core RTL.
module steering_angle_from_quaternions_core_tb;
    import safq_pkg::*;

    localparam int LATENCY = 2 + CSTAGES + 3;
    localparam int WATCHDOG_LIMIT = 4000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_item;
    logic       psel = 1'b0;
    logic       penable = 1'b0;
    logic       pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic       pready;

    always #1 i_clk = ~i_clk;

    steering_angle_from_quaternions_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copy of the registers.
    logic              cal_sh;
    longint            frame_ofs_sh, fork_ofs_sh, steer_ofs_sh, disp_ofs_sh;

    t_out_item angle_queue[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  quiet_phase = 1'b0;
    bit  long_hold = 1'b0;

    longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint wrap_deg(longint v);
        if (v > HALF_TURN) v -= ((v - HALF_TURN + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
        else if (v < -HALF_TURN)
            v += ((-HALF_TURN - v + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
        return v;
    endfunction

    function automatic longint yaw_deg128(longint w, longint x, longint y, longint z);
        longint t3, t4, cx, cy, ang, dx, dy;
        t3 = 2 * (w * z + x * y);
        t4 = (longint'(1) << 28) - 2 * (y * y + z * z);
        cx = t4;
        cy = t3;
        ang = 0;
        if (t3 == 0 && t4 == 0) return 0;
        // Left half plane: turn by half a revolution first.
        if (cx < 0) begin
            ang = (cy >= 0) ? 180 * 65536 : -180 * 65536;
            cx = -cx;
            cy = -cy;
        end
        for (int i = 0; i < CSTAGES; i++) begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (cy > 0) begin
                cx += dx; cy -= dy; ang += atan_tab[i];
            end else begin
                cx -= dx; cy += dy; ang -= atan_tab[i];
            end
        end
        return floor_shift(ang + 256, 9);
    endfunction

    function automatic t_out_item predict_angles(t_in_item q);
        longint yf, yk, st;
        t_out_item r;
        yf = yaw_deg128(q.frame_qw, q.frame_qx, q.frame_qy, q.frame_qz);
        yk = yaw_deg128(q.fork_qw, q.fork_qx, q.fork_qy, q.fork_qz);
        if (cal_sh) begin
            yf -= frame_ofs_sh;
            yk -= fork_ofs_sh;
        end
        st = yk - yf - (cal_sh ? steer_ofs_sh : 0);
        r.steering_angle = 16'(wrap_deg(st));
        r.frame_yaw = 16'(wrap_deg(yf - disp_ofs_sh));
        return r;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * int'(idx)); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_CALIBRATED:  cal_sh = val[0];
            REG_FRAME_OFS:   frame_ofs_sh = longint'($signed(val[15:0]));
            REG_FORK_OFS:    fork_ofs_sh = longint'($signed(val[15:0]));
            REG_STEER_OFS:   steer_ofs_sh = longint'($signed(val[15:0]));
            REG_DISPLAY_OFS: disp_ofs_sh = longint'($signed(val[16:0]));
            default: ;
        endcase
    endtask

    task automatic write_all(logic cal, int fo, int ko, int so, int dof);
        write_reg(REG_CALIBRATED, 32'(cal));
        write_reg(REG_FRAME_OFS, 32'(fo));
        write_reg(REG_FORK_OFS, 32'(ko));
        write_reg(REG_STEER_OFS, 32'(so));
        write_reg(REG_DISPLAY_OFS, 32'(dof));
    endtask

    task automatic drain();
        while (angle_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Sends one transaction; a random idle burst may come before it.
    task automatic send_pair(t_in_item q);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= q;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        angle_queue.push_back(predict_angles(q));
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 32768) - 16384);
            1: return 16'($urandom);
            2: return 16'($urandom_range(0, 64) - 32);
            default: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        endcase
    endfunction

    // Roughly unit quaternions dominate; raw patterns cover the remaining bits.
    function automatic t_in_item rand_pair();
        t_in_item q;
        real a, b;
        if ($urandom_range(0, 3) != 0) begin
            a = ($urandom_range(0, 62831) / 10000.0);
            b = ($urandom_range(0, 62831) / 10000.0);
            q.frame_qw = 16'($rtoi(16384.0 * $cos(a / 2.0)));
            q.frame_qz = 16'($rtoi(16384.0 * $sin(a / 2.0)));
            q.frame_qx = 16'($urandom_range(0, 200) - 100);
            q.frame_qy = 16'($urandom_range(0, 200) - 100);
            q.fork_qw = 16'($rtoi(16384.0 * $cos(b / 2.0)));
            q.fork_qz = 16'($rtoi(16384.0 * $sin(b / 2.0)));
            q.fork_qx = 16'($urandom_range(0, 200) - 100);
            q.fork_qy = 16'($urandom_range(0, 200) - 100);
        end else begin
            q = {rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                 rand_comp(), rand_comp(), rand_comp(), rand_comp()};
        end
        return q;
    endfunction

    // Receiver: random stall bursts with a gap after each, one long
    // hold-off on request.
    always @(posedge i_clk) begin
        if (long_hold) begin
            i_out_stall <= 1'b1;
            stall_left <= 0;
        end else if (quiet_phase) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!i_out_stall && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= int'($urandom_range(0, 13));
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (angle_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_out_item);
            end else begin
                exp_r = angle_queue.pop_front();
                if (exp_r.steering_angle !== o_out_item.steering_angle ||
                    exp_r.frame_yaw !== o_out_item.frame_yaw) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected steer %0d yaw %0d, got steer %0d yaw %0d",
                            exp_r.steering_angle, exp_r.frame_yaw,
                            o_out_item.steering_angle, o_out_item.frame_yaw);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("steering_angle_from_quaternions_core test failed");
            $finish;
        end
    end

    typedef struct {
        t_in_item q;
        bit       known;
        t_out_item r;
    } t_directed_row;

    initial begin
        t_directed_row rows[$];
        int phase;
        cal_sh = 0; frame_ofs_sh = 0; fork_ofs_sh = 0; steer_ofs_sh = 0; disp_ofs_sh = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Identity both, zero vector, extremes, negative t4 with both signs of t3.
        rows.push_back('{'{16384, 0, 0, 0, 16384, 0, 0, 0}, 1, '{0, 0}});
        rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0}, 0, '0});
        rows.push_back('{'{0, 0, 0, 16384, 16384, 0, 0, 0}, 0, '0});
        rows.push_back('{'{0, 0, 0, -16384, 0, 0, 0, 16384}, 0, '0});
        rows.push_back('{'{-16384, -16384, -16384, -16384, 16384, 16384, 16384, 16384},
            0, '0});
        rows.push_back('{'{16'h8000, 16'h8000, 16'h8000, 16'h8000,
            16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 0, '0});
        rows.push_back('{'{11585, 0, 0, 11585, 11585, 0, 0, -11585}, 0, '0});
        rows.push_back('{'{0, 16384, 0, 0, 0, 0, 16384, 0}, 0, '0});
        rows.push_back('{'{1, 0, 0, -16384, 1, 0, 0, 16384}, 0, '0});
        rows.push_back('{'{16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
            16'haaaa, 16'h5555, 16'haaaa, 16'h5555}, 0, '0});
        foreach (rows[i]) begin
            send_pair(rows[i].q);
            if (rows[i].known && angle_queue[$] !== rows[i].r) begin
                mismatches++;
                $display("directed row %0d: predictor disagrees with table", i);
            end
        end
        i_in_valid <= 1'b0;
        drain();

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_all(1, 23040, -23040, 23040, -46080);
                1: write_all(1, -32768, 32767, -32768, 65535);
                2: write_all(0, 1234, -999, 777, 46080);
                3: write_all(1, $urandom_range(0, 46080) - 23040,
                    $urandom_range(0, 46080) - 23040, $urandom_range(0, 46080) - 23040,
                    $urandom_range(0, 92160) - 46080);
                default: write_all(1, 0, 0, 0, 0);
            endcase
            foreach (rows[i]) send_pair(rows[i].q);
            if (phase == 1) begin
                // Hold the output off long enough for the pipe to fill and stall.
                fork
                    begin
                        long_hold = 1'b1;
                        repeat (LATENCY * 3) @(posedge i_clk);
                        long_hold = 1'b0;
                    end
                    repeat (40) send_pair(rand_pair());
                join
            end
            if (phase == 4) quiet_phase = 1'b1;
            repeat (120) send_pair(rand_pair());
            i_in_valid <= 1'b0;
            drain();
        end

        if (mismatches == 0) $display("steering_angle_from_quaternions_core test passed");
        else $display("steering_angle_from_quaternions_core test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/safq_pkg.sv
rtl/safq_regs.sv
rtl/safq_prep.sv
rtl/safq_cordic.sv
rtl/safq_post.sv
rtl/steering_angle_from_quaternions_core.sv
dv/steering_angle_from_quaternions_core_tb.sv
